// ----- rtl/core/interleaved_screen_block_blitter_assert.svh -----
// Assertion macros for the screen block blitter checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef INTERLEAVED_SCREEN_BLOCK_BLITTER_ASSERT_SVH
`define INTERLEAVED_SCREEN_BLOCK_BLITTER_ASSERT_SVH

// Same-cycle implication, quiet while in reset
`define ISBB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("isbb assertion failed");

// Next-cycle implication, quiet while in reset
`define ISBB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("isbb assertion failed");

// Next-cycle implication that also holds across reset
`define ISBB_ASSERT_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("isbb assertion failed");

`endif

// ----- rtl/core/isbb_pkg.sv -----
// Shared types and constants for the screen block blitter.
// No dependencies.
package isbb_pkg;

    // Command codes
    localparam logic [2:0] CMD_PIX_WR  = 3'd0;
    localparam logic [2:0] CMD_ATTR_WR = 3'd1;
    localparam logic [2:0] CMD_PIX_RD  = 3'd2;
    localparam logic [2:0] CMD_ATTR_RD = 3'd3;
    localparam logic [2:0] CMD_RESTART = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_SCREEN_BASE   = 3'd0;
    localparam logic [2:0] REG_LEFT_COLUMN   = 3'd1;
    localparam logic [2:0] REG_TOP_ROW       = 3'd2;
    localparam logic [2:0] REG_WIDTH_BLOCKS  = 3'd3;
    localparam logic [2:0] REG_HEIGHT_BLOCKS = 3'd4;

    localparam logic [15:0] ATTR_OFFSET   = 16'd6144;
    localparam logic [15:0] BASE_RESET    = 16'h4000;
    localparam logic [8:0]  LAST_LINE     = 9'd191;
    localparam logic [5:0]  LAST_ROW      = 6'd23;
    localparam logic [5:0]  MAX_WIDTH     = 6'd32;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] address;
        logic [7:0]  wdata;
        logic        is_read;
        logic        last;
        logic        outside;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] screen_base;
        logic [4:0]  left_column;
        logic [4:0]  top_row;
        logic [5:0]  width_blocks;
        logic [4:0]  height_blocks;
    } t_cfg;

endpackage

// ----- rtl/core/isbb_walker.sv -----
// Pixel and attribute cursors with the address logic for one beat.
// Depends on isbb_pkg.
module isbb_walker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  isbb_pkg::t_cfg     i_cfg,
    input  logic               i_step,
    input  isbb_pkg::t_in_beat i_beat,
    output logic               o_has_result,
    output isbb_pkg::t_out_beat o_beat
);
    import isbb_pkg::*;

    logic [4:0] r_pcol, n_pcol;
    logic [7:0] r_pline, n_pline;
    logic [4:0] r_acol, n_acol;
    logic [4:0] r_arow, n_arow;

    logic [5:0]  w_eff;
    logic [4:0]  h_eff;
    logic [7:0]  pix_rows;
    logic [8:0]  line;
    logic [7:0]  il_line;
    logic [5:0]  pcol_abs, acol_abs, arow_abs;
    logic        pix_off, attr_off;
    logic [15:0] pix_addr, attr_addr;
    logic        is_pix, is_attr;
    logic        pcol_wrap, pline_wrap, acol_wrap, arow_wrap;

    // Effective rectangle size: zero reads as one, width saturates at 32
    always_comb begin
        if (i_cfg.width_blocks == 6'd0) begin
            w_eff = 6'd1;
        end else if (i_cfg.width_blocks > MAX_WIDTH) begin
            w_eff = MAX_WIDTH;
        end else begin
            w_eff = i_cfg.width_blocks;
        end
        h_eff    = (i_cfg.height_blocks == 5'd0) ? 5'd1 : i_cfg.height_blocks;
        pix_rows = {h_eff, 3'b000};
    end

    // Pixel address: interleave thirds, character rows and scan lines
    always_comb begin
        line     = {1'b0, i_cfg.top_row, 3'b000} + {1'b0, r_pline};
        pcol_abs = {1'b0, i_cfg.left_column} + {1'b0, r_pcol};
        pix_off  = pcol_abs[5] || (line > LAST_LINE);
        il_line  = {line[7:6], line[2:0], line[5:3]};
        pix_addr = i_cfg.screen_base + {3'b000, il_line, 5'b00000}
                   + {10'd0, pcol_abs};
    end

    // Attribute address
    always_comb begin
        arow_abs  = {1'b0, i_cfg.top_row} + {1'b0, r_arow};
        acol_abs  = {1'b0, i_cfg.left_column} + {1'b0, r_acol};
        attr_off  = acol_abs[5] || (arow_abs > LAST_ROW);
        attr_addr = i_cfg.screen_base + ATTR_OFFSET + {5'd0, arow_abs, 5'b00000}
                    + {10'd0, acol_abs};
    end

    // Cursor wrap tests
    always_comb begin
        pcol_wrap  = !(({1'b0, r_pcol} + 6'd1) < w_eff);
        pline_wrap = !(({1'b0, r_pline} + 9'd1) < {1'b0, pix_rows});
        acol_wrap  = !(({1'b0, r_acol} + 6'd1) < w_eff);
        arow_wrap  = !(({1'b0, r_arow} + 6'd1) < {1'b0, h_eff});
    end

    // Result beat and next cursor values
    always_comb begin
        is_pix  = (i_beat.cmd == CMD_PIX_WR) || (i_beat.cmd == CMD_PIX_RD);
        is_attr = (i_beat.cmd == CMD_ATTR_WR) || (i_beat.cmd == CMD_ATTR_RD);
        o_has_result   = is_pix || is_attr;
        o_beat.is_read = (i_beat.cmd == CMD_PIX_RD) || (i_beat.cmd == CMD_ATTR_RD);
        o_beat.outside = is_pix ? pix_off : attr_off;
        o_beat.address = o_beat.outside ? 16'd0 : (is_pix ? pix_addr : attr_addr);
        o_beat.wdata   = (o_beat.is_read || o_beat.outside) ? 8'd0 : i_beat.data;
        o_beat.last    = is_pix ? (pcol_wrap && pline_wrap) : (acol_wrap && arow_wrap);

        n_pcol  = r_pcol;
        n_pline = r_pline;
        n_acol  = r_acol;
        n_arow  = r_arow;
        if (i_step) begin
            if (i_beat.cmd == CMD_RESTART) begin
                n_pcol  = '0;
                n_pline = '0;
                n_acol  = '0;
                n_arow  = '0;
            end else if (is_pix) begin
                n_pcol = pcol_wrap ? 5'd0 : r_pcol + 5'd1;
                if (pcol_wrap) begin
                    n_pline = pline_wrap ? 8'd0 : r_pline + 8'd1;
                end
            end else if (is_attr) begin
                n_acol = acol_wrap ? 5'd0 : r_acol + 5'd1;
                if (acol_wrap) begin
                    n_arow = arow_wrap ? 5'd0 : r_arow + 5'd1;
                end
            end
        end
    end

    // Cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcol  <= '0;
            r_pline <= '0;
            r_acol  <= '0;
            r_arow  <= '0;
        end else begin
            r_pcol  <= n_pcol;
            r_pline <= n_pline;
            r_acol  <= n_acol;
            r_arow  <= n_arow;
        end
    end

endmodule

// ----- rtl/core/interleaved_screen_block_blitter.sv -----
// Top level of the screen block blitter: config registers, input and result registers.
// Depends on isbb_pkg and isbb_walker.
//
//  channel | signals                       | beat
//  --------+-------------------------------+--------------------------------
//  in      | i_valid / o_ready / i_beat    | command and data byte
//  out     | o_valid / i_ready / o_beat    | address, wdata and flags
//  cfg     | i_cfg_we / i_cfg_idx / i_cfg_data | register write, no wait
//
// One beat per cycle sustained while the output does not stall. A beat sits in
// the input register, where the cursor walker forms its address and steps, then
// moves into the result register, where o_valid flags it. Restart and unknown
// commands give no result and never wait on the output. Synchronous active-low
// reset clears cursors and valid flags and sets the configuration to its
// defaults. A stalled output holds the input stage once both registers are full.
module interleaved_screen_block_blitter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  isbb_pkg::t_in_beat  i_beat,
    output logic                o_valid,
    input  logic                i_ready,
    output isbb_pkg::t_out_beat o_beat,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);
    import isbb_pkg::*;

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;

    logic      has_result;
    t_out_beat calc_beat;
    logic      out_free;
    logic      in_go;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_base   <= BASE_RESET;
            r_cfg.left_column   <= 5'd0;
            r_cfg.top_row       <= 5'd0;
            r_cfg.width_blocks  <= 6'd1;
            r_cfg.height_blocks <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SCREEN_BASE:   r_cfg.screen_base   <= i_cfg_data;
                REG_LEFT_COLUMN:   r_cfg.left_column   <= i_cfg_data[4:0];
                REG_TOP_ROW:       r_cfg.top_row       <= i_cfg_data[4:0];
                REG_WIDTH_BLOCKS:  r_cfg.width_blocks  <= i_cfg_data[5:0];
                REG_HEIGHT_BLOCKS: r_cfg.height_blocks <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Flow control: the input stage moves on when it has no result or its result has a place to go
    assign out_free = !r_out_valid || i_ready;
    assign in_go    = r_in_valid && (!has_result || out_free);
    assign o_ready  = !r_in_valid || in_go;

    isbb_walker u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_step       (in_go),
        .i_beat       (r_in),
        .o_has_result (has_result),
        .o_beat       (calc_beat)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_beat;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= in_go && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && in_go && has_result) begin
            r_out <= calc_beat;
        end
    end

    assign o_valid = r_out_valid;
    assign o_beat  = r_out;

endmodule

// ----- rtl/core/isbb_checker.sv -----
// Port-level checks for the screen block blitter, bound to the top level.
// Depends on isbb_pkg and interleaved_screen_block_blitter_assert.svh.
`include "interleaved_screen_block_blitter_assert.svh"

module isbb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input isbb_pkg::t_out_beat o_beat
);
    import isbb_pkg::*;

    // Reads never carry write data
    `ISBB_ASSERT_SAME(a_read_no_data, o_valid && o_beat.is_read, o_beat.wdata == 8'd0)

    // Suppressed accesses show a zero address and zero data
    `ISBB_ASSERT_SAME(a_outside_zero, o_valid && o_beat.outside,
                      (o_beat.address == 16'd0) && (o_beat.wdata == 8'd0))

    // A stalled result beat holds
    `ISBB_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_beat))

    // Nothing leaves straight out of reset
    `ISBB_ASSERT_NEXT_RST(a_rst_quiet, !i_rst_n, !o_valid)

endmodule

bind interleaved_screen_block_blitter isbb_checker u_isbb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_beat  (o_beat)
);

// ----- sim/tb_interleaved_screen_block_blitter.sv -----
// Self-checking testbench for the interleaved screen block blitter.
// Depends on isbb_pkg and the blitter RTL; predicts each access beat and
// checks it against the result channel.
`timescale 1ns / 100ps

module tb_interleaved_screen_block_blitter;
    import isbb_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int LAST_COL       = 31;
    localparam int ROW_BYTES      = 32;
    localparam int LINES_PER_ROW  = 8;

    // Codes the block must ignore
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam logic [2:0] REG_UNUSED    = 3'd7;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_ready;
    t_in_beat    i_beat     = '0;
    logic        o_valid;
    logic        i_ready    = 1'b0;
    t_out_beat   o_beat;
    logic        i_cfg_we   = 1'b0;
    logic [2:0]  i_cfg_idx  = '0;
    logic [15:0] i_cfg_data = '0;

    // Predictor state: register copy and both cursors
    t_cfg blit_cfg;
    int   pix_col, pix_line, attr_col, attr_row;

    t_out_beat pending_access_q[$];
    t_out_beat want_access;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int hold_taken  = 0;
    int hold_left   = 0;
    int mismatches  = 0;
    int cycle_count = 0;

    interleaved_screen_block_blitter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_beat     (i_beat),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_beat     (o_beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Line number to its row slot in the interleaved pixel area
    function automatic int interleave_line(input int line);
        return (line & 'hC0) | ((line & 7) << 3) | ((line >> 3) & 7);
    endfunction

    // Row-major step; high when the pass has just wrapped
    function automatic bit step_cursor(inout int col, inout int row,
                                       input int cols, input int rows);
        if (col + 1 < cols) begin
            col++;
            return 1'b0;
        end
        col = 0;
        if (row + 1 < rows) begin
            row++;
            return 1'b0;
        end
        row = 0;
        return 1'b1;
    endfunction

    function automatic bit predict_access(input t_in_beat b, output t_out_beat r);
        int w, h, line, row, col, addr;
        bit off, rd, wrap;
        r = '0;
        w = int'(blit_cfg.width_blocks);
        if (w == 0) w = 1;
        else if (w > int'(MAX_WIDTH)) w = int'(MAX_WIDTH);
        h = int'(blit_cfg.height_blocks);
        if (h == 0) h = 1;
        if (b.cmd == CMD_RESTART) begin
            pix_col  = 0;
            pix_line = 0;
            attr_col = 0;
            attr_row = 0;
            return 1'b0;
        end
        if (b.cmd > CMD_RESTART) return 1'b0;
        rd   = (b.cmd == CMD_PIX_RD) || (b.cmd == CMD_ATTR_RD);
        addr = 0;
        if (b.cmd == CMD_PIX_WR || b.cmd == CMD_PIX_RD) begin
            line = int'(blit_cfg.top_row) * LINES_PER_ROW + pix_line;
            col  = int'(blit_cfg.left_column) + pix_col;
            off  = (col > LAST_COL) || (line > int'(LAST_LINE));
            if (!off)
                addr = int'(blit_cfg.screen_base) + ROW_BYTES * interleave_line(line) + col;
            wrap = step_cursor(pix_col, pix_line, w, h * LINES_PER_ROW);
        end else begin
            row  = int'(blit_cfg.top_row) + attr_row;
            col  = int'(blit_cfg.left_column) + attr_col;
            off  = (col > LAST_COL) || (row > int'(LAST_ROW));
            if (!off)
                addr = int'(blit_cfg.screen_base) + int'(ATTR_OFFSET) + ROW_BYTES * row + col;
            wrap = step_cursor(attr_col, attr_row, w, h);
        end
        r.address = 16'(addr);
        r.wdata   = (rd || off) ? 8'h00 : b.data;
        r.is_read = rd;
        r.last    = wrap;
        r.outside = off;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Result side: random ready, long hold-off on request, checking
    // ---------------------------------------------------------------

    task automatic note_mismatch(input string what, input t_out_beat want_b,
                                 input t_out_beat got_b);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display({"%0t %s: want addr %h wdata %h rd %b last %b out %b,",
                      " got addr %h wdata %h rd %b last %b out %b"},
                     $time, what, want_b.address, want_b.wdata, want_b.is_read,
                     want_b.last, want_b.outside, got_b.address, got_b.wdata,
                     got_b.is_read, got_b.last, got_b.outside);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_access_q.size() == 0) begin
                note_mismatch("beat with nothing pending", '0, o_beat);
            end else begin
                want_access = pending_access_q.pop_front();
                if (o_beat.address !== want_access.address ||
                    o_beat.wdata   !== want_access.wdata   ||
                    o_beat.is_read !== want_access.is_read ||
                    o_beat.last    !== want_access.last    ||
                    o_beat.outside !== want_access.outside)
                    note_mismatch("beat mismatch", want_access, o_beat);
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_req != hold_taken) begin
            hold_taken = hold_req;
            hold_left  = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Offer one beat, with random gaps ahead of it; predicts on acceptance
    task automatic send_beat(input logic [2:0] cmd, input logic [7:0] data);
        t_in_beat  b;
        t_out_beat r;
        b.cmd  = cmd;
        b.data = data;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            i_beat  <= t_in_beat'($urandom);
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_beat  <= b;
        do @(posedge i_clk); while (!o_ready);
        if (predict_access(b, r))
            pending_access_q.push_back(r);
    endtask

    // Stop offering and wait until the block has gone quiet
    task automatic drain_block();
        i_valid <= 1'b0;
        while (pending_access_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; bits above the register width carry noise
    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] value,
                             input logic [15:0] mask);
        logic [15:0] d;
        d = (16'($urandom) & ~mask) | (value & mask);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        case (idx)
            REG_SCREEN_BASE:   blit_cfg.screen_base   = d;
            REG_LEFT_COLUMN:   blit_cfg.left_column   = d[4:0];
            REG_TOP_ROW:       blit_cfg.top_row       = d[4:0];
            REG_WIDTH_BLOCKS:  blit_cfg.width_blocks  = d[5:0];
            REG_HEIGHT_BLOCKS: blit_cfg.height_blocks = d[4:0];
            default: ;
        endcase
    endtask

    // All registers, then a write to an unused index that must change nothing
    task automatic set_cfg(input t_cfg c);
        cfg_write(REG_SCREEN_BASE,   c.screen_base,           16'hFFFF);
        cfg_write(REG_LEFT_COLUMN,   16'(c.left_column),      16'h001F);
        cfg_write(REG_TOP_ROW,       16'(c.top_row),          16'h001F);
        cfg_write(REG_WIDTH_BLOCKS,  16'(c.width_blocks),     16'h003F);
        cfg_write(REG_HEIGHT_BLOCKS, 16'(c.height_blocks),    16'h001F);
        cfg_write(REG_UNUSED,        16'($urandom),           16'h0000);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly small rectangles so passes wrap often; some edge sizes
    function automatic t_cfg rand_cfg();
        t_cfg c;
        int   r;
        c.screen_base = 16'($urandom);
        c.left_column = 5'($urandom_range(0, 31));
        c.top_row     = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 23))
                                                     : 5'($urandom_range(24, 31));
        r = $urandom_range(0, 99);
        if (r < 80)      c.width_blocks = 6'($urandom_range(1, 4));
        else if (r < 88) c.width_blocks = 6'd0;
        else if (r < 94) c.width_blocks = 6'($urandom_range(5, 32));
        else             c.width_blocks = 6'($urandom_range(33, 63));
        r = $urandom_range(0, 99);
        if (r < 80)      c.height_blocks = 5'($urandom_range(1, 3));
        else if (r < 88) c.height_blocks = 5'd0;
        else             c.height_blocks = 5'($urandom_range(4, 31));
        return c;
    endfunction

    function automatic logic [2:0] rand_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 32) return CMD_PIX_WR;
        if (r < 52) return CMD_ATTR_WR;
        if (r < 72) return CMD_PIX_RD;
        if (r < 90) return CMD_ATTR_RD;
        if (r < 95) return CMD_RESTART;
        return 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset register values, every command, restart mid-pass, unknown codes
    task automatic test_defaults();
        send_beat(CMD_PIX_WR,    8'hFF);
        send_beat(CMD_PIX_WR,    8'h00);
        send_beat(CMD_ATTR_WR,   8'hA5);
        send_beat(CMD_PIX_RD,    8'h3C);
        send_beat(CMD_ATTR_RD,   8'hFF);
        send_beat(CMD_RESTART,   8'h00);
        send_beat(CMD_UNUSED_LO, 8'h5A);
        send_beat(CMD_UNUSED_HI, 8'hFF);
        send_beat(CMD_PIX_WR,    8'h81);
    endtask

    // Register extremes: address wrap, saturated width, zero sizes, off-screen
    task automatic test_extremes();
        drain_block();
        set_cfg('{16'hFFFF, 5'd31, 5'd23, 6'd32, 5'd24});
        send_beat(CMD_PIX_WR,  8'h7E);
        send_beat(CMD_ATTR_WR, 8'h01);
        send_beat(CMD_ATTR_RD, 8'hC3);
        drain_block();
        set_cfg('{16'h0000, 5'd30, 5'd31, 6'd63, 5'd0});
        send_beat(CMD_PIX_WR,  8'hAA);
        send_beat(CMD_ATTR_WR, 8'h55);
        send_beat(CMD_PIX_RD,  8'h0F);
        drain_block();
        set_cfg('{BASE_RESET, 5'd0, 5'd23, 6'd0, 5'd31});
        send_beat(CMD_RESTART, 8'hF0);
        send_beat(CMD_ATTR_WR, 8'h12);
        send_beat(CMD_ATTR_WR, 8'h34);
        send_beat(CMD_PIX_WR,  8'h56);
        send_beat(CMD_PIX_WR,  8'h78);
        send_beat(CMD_PIX_WR,  8'h9A);
    endtask

    // Random beats in chunks, with a fresh register set between chunks
    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_items);
        int         done;
        int         chunk;
        logic [2:0] c;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        done = 0;
        while (done < n_items) begin
            drain_block();
            set_cfg(rand_cfg());
            chunk = $urandom_range(40, 90);
            if (chunk > n_items - done) chunk = n_items - done;
            repeat (chunk) begin
                c = rand_cmd();
                send_beat(c, 8'($urandom));
                done++;
            end
        end
    endtask

    // Receiver holds off for a long stretch while beats keep coming
    task automatic test_backpressure();
        logic [2:0] c;
        drain_block();
        set_cfg(rand_cfg());
        tx_idle_pct = 0;
        hold_req++;
        repeat (50) begin
            c = 3'($urandom_range(CMD_PIX_WR, CMD_ATTR_RD));
            send_beat(c, 8'($urandom));
        end
    endtask

    initial begin
        blit_cfg = '{BASE_RESET, 5'd0, 5'd0, 6'd1, 5'd1};
        pix_col  = 0;
        pix_line = 0;
        attr_col = 0;
        attr_row = 0;
        tx_idle_pct = 14;
        rx_idle_pct = 51;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_extremes();
        test_random_phase(14, 51, 620);
        test_backpressure();
        test_random_phase(51, 14, 620);
        test_random_phase(0, 0, 620);
        drain_block();

        if (mismatches == 0 && pending_access_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/isbb_pkg.sv
rtl/core/isbb_walker.sv
rtl/core/interleaved_screen_block_blitter.sv
rtl/core/isbb_checker.sv
sim/tb_interleaved_screen_block_blitter.sv
